### rtl/core/sensor_ring_moving_average_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor ring moving average core
// Implication checks, same cycle and next cycle, under synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_RING_MOVING_AVERAGE_CORE_ASSERT_SVH
`define SENSOR_RING_MOVING_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication
`define SRMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srma check failed");

// next-cycle implication
`define SRMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srma check failed");

`endif

### rtl/core/srma_pkg.sv
// ----------------------------------------------------------------------------
// srma_pkg
// Shared widths, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srma_pkg;

  localparam int FIELD_W         = 16;
  localparam int CNT_W           = 7;
  localparam int SUM_W           = FIELD_W + CNT_W;
  localparam int REC_W           = 4 * FIELD_W;
  localparam int LANES           = 4;
  localparam int DIV_CNT_W       = $clog2(SUM_W + 1);
  localparam int RC_MAX          = (2 ** CNT_W) - 1;
  localparam int RING_SLOTS_DEF  = 64;

  localparam logic [CNT_W-1:0] RC_RST = CNT_W'(64);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } srma_state_t;

  typedef struct packed {
    logic cfg_wr;
    logic clear_start;
    logic clear;
    logic rec_wr;
    logic scan_start;
    logic scan;
    logic div_start;
    logic out_load;
  } srma_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic div_done;
  } srma_stat_t;

endpackage

### rtl/core/srma_div.sv
// ----------------------------------------------------------------------------
// srma_div
// Four-lane restoring divider, one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srma_div
  import srma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend [LANES],
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient [LANES]
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]     dvs_r;
  logic [CNT_W-1:0]     rem_r [LANES];
  logic [CNT_W-1:0]     rem_nxt [LANES];
  logic [SUM_W-1:0]     quo_r [LANES];
  logic [SUM_W-1:0]     quo_nxt [LANES];

  always_comb begin
    logic [CNT_W:0] trial;
    logic           ge;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    for (int l = 0; l < LANES; l++) begin
      trial      = {rem_r[l], quo_r[l][SUM_W-1]};
      ge         = (trial >= {1'b0, dvs_r});
      rem_nxt[l] = ge ? CNT_W'(trial - {1'b0, dvs_r}) : CNT_W'(trial);
      quo_nxt[l] = {quo_r[l][SUM_W-2:0], ge};
    end
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + DIV_CNT_W'(1);
      if (step_r == DIV_CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      for (int l = 0; l < LANES; l++) begin
        rem_r[l] <= '0;
        quo_r[l] <= dividend[l];
      end
    end else if (busy_r) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[l] <= rem_nxt[l];
        quo_r[l] <= quo_nxt[l];
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/srma_ctrl.sv
// ----------------------------------------------------------------------------
// srma_ctrl
// Sequencer: clear pass, record write, ring scan, divide, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srma_ctrl
  import srma_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  output logic       out_valid,
  input  logic       out_stall,
  input  srma_stat_t stat,
  output srma_cmd_t  cmd
);

  srma_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        cfg_fire;
  logic        in_fire;

  assign cfg_ready = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        if (cfg_fire) begin
          cmd.cfg_wr      = 1'b1;
          cmd.clear_start = 1'b1;
        end else if (stat.clear_done) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.clear = 1'b1;
        end
      end
      ST_IDLE: begin
        if (cfg_fire) begin
          cmd.cfg_wr      = 1'b1;
          cmd.clear_start = 1'b1;
          state_nxt       = ST_CLEAR;
        end else if (in_fire) begin
          cmd.rec_wr     = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/srma_dp.sv
// ----------------------------------------------------------------------------
// srma_dp
// Ring store, write pointer, scan accumulators, divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srma_dp
  import srma_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  srma_cmd_t                 cmd,
  output srma_stat_t                stat,
  input  logic        [CNT_W-1:0]   cfg_record_count,
  input  logic signed [FIELD_W-1:0] in_sample_temperature,
  input  logic        [FIELD_W-1:0] in_sample_humidity,
  input  logic        [FIELD_W-1:0] in_sample_lux,
  input  logic        [FIELD_W-1:0] in_sample_noise,
  output logic signed [FIELD_W-1:0] out_avg_temperature,
  output logic        [FIELD_W-1:0] out_avg_humidity,
  output logic        [FIELD_W-1:0] out_avg_lux,
  output logic        [FIELD_W-1:0] out_avg_noise,
  output logic        [CNT_W-1:0]   out_valid_count
);

  localparam int AW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam logic [CNT_W-1:0] N_MAX =
    CNT_W'((RING_SLOTS > RC_MAX) ? RC_MAX : RING_SLOTS);

  logic [REC_W-1:0] mem [RING_SLOTS];

  logic        [CNT_W-1:0] rc_r;
  logic        [CNT_W-1:0] n_act;
  logic        [CNT_W-1:0] idx_r, idx_nxt;
  logic        [CNT_W-1:0] wp_r, wp_nxt;
  logic        [CNT_W:0]   wp_inc;
  logic                    idx_lt;
  logic                    rd_vld_r;
  logic        [REC_W-1:0] rd_r;
  logic signed [SUM_W-1:0] sum_t_r;
  logic        [SUM_W-1:0] sum_h_r, sum_l_r, sum_n_r;
  logic        [CNT_W-1:0] cnt_r;
  logic                    neg_r;

  logic                    mem_we;
  logic        [AW-1:0]    mem_waddr;
  logic        [REC_W-1:0] mem_wdata;

  logic        [SUM_W-1:0] dvd [LANES];
  logic        [SUM_W-1:0] quo [LANES];
  logic                    div_done;
  logic        [FIELD_W-1:0] q_t;

  assign n_act  = (rc_r > N_MAX) ? N_MAX : rc_r;
  assign idx_lt = (idx_r < n_act);
  assign wp_inc = {1'b0, wp_r} + (CNT_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= RC_RST;
    end else if (cmd.cfg_wr) begin
      rc_r <= cfg_record_count;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clear_start || cmd.scan_start) begin
      idx_nxt = '0;
    end else if ((cmd.clear || cmd.scan) && idx_lt) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
    wp_nxt = wp_r;
    if (cmd.clear_start) begin
      wp_nxt = '0;
    end else if (cmd.rec_wr && (n_act != '0)) begin
      wp_nxt = (wp_inc >= {1'b0, n_act}) ? '0 : CNT_W'(wp_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      wp_r     <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      wp_r     <= wp_nxt;
      rd_vld_r <= cmd.scan && idx_lt;
    end
  end

  always_comb begin
    mem_we    = (cmd.clear && idx_lt) || (cmd.rec_wr && (n_act != '0));
    mem_waddr = cmd.clear ? AW'(idx_r) : AW'(wp_r);
    mem_wdata = cmd.clear ? '0 : {in_sample_temperature, in_sample_humidity,
                                  in_sample_lux, in_sample_noise};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && idx_lt) begin
      rd_r <= mem[AW'(idx_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      sum_t_r <= '0;
      sum_h_r <= '0;
      sum_l_r <= '0;
      sum_n_r <= '0;
      cnt_r   <= '0;
    end else if (rd_vld_r && (rd_r != '0)) begin
      sum_t_r <= sum_t_r + {{(SUM_W-FIELD_W){rd_r[REC_W-1]}}, rd_r[REC_W-1 -: FIELD_W]};
      sum_h_r <= sum_h_r + SUM_W'(rd_r[3*FIELD_W-1 -: FIELD_W]);
      sum_l_r <= sum_l_r + SUM_W'(rd_r[2*FIELD_W-1 -: FIELD_W]);
      sum_n_r <= sum_n_r + SUM_W'(rd_r[FIELD_W-1:0]);
      cnt_r   <= cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    dvd[0] = sum_t_r[SUM_W-1] ? (~sum_t_r + SUM_W'(1)) : sum_t_r;
    dvd[1] = sum_h_r;
    dvd[2] = sum_l_r;
    dvd[3] = sum_n_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= sum_t_r[SUM_W-1];
    end
  end

  srma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign q_t = quo[0][FIELD_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cnt_r == '0) begin
        out_avg_temperature <= '0;
        out_avg_humidity    <= '0;
        out_avg_lux         <= '0;
        out_avg_noise       <= '0;
        out_valid_count     <= '0;
      end else begin
        out_avg_temperature <= neg_r ? (~q_t + FIELD_W'(1)) : q_t;
        out_avg_humidity    <= quo[1][FIELD_W-1:0];
        out_avg_lux         <= quo[2][FIELD_W-1:0];
        out_avg_noise       <= quo[3][FIELD_W-1:0];
        out_valid_count     <= cnt_r;
      end
    end
  end

  always_comb begin
    stat.clear_done = !idx_lt;
    stat.scan_done  = (idx_r == n_act) && !rd_vld_r;
    stat.div_done   = div_done;
  end

endmodule

### rtl/core/sensor_ring_moving_average_core.sv
// ----------------------------------------------------------------------------
// sensor_ring_moving_average_core
// Ring of sensor records with per-field means over the non-empty slots.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | in_sample_temperature/humidity/lux/noise
//  out     | out_valid / out_stall| out_avg_* , out_valid_count
//  cfg     | cfg_valid / cfg_ready| cfg_record_count
//
//  Each item, with n the active slot count, runs a ring scan of the n slots,
//  a four-lane bit-serial divide, an output load and a return to idle.
//  After reset and after every cfg write a clear pass over the n slots runs
//  with in_stall high; cfg writes are taken during it.
//  A finished result waits in the output register; the next item is taken
//  meanwhile and its result holds until out_stall drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_ring_moving_average_core
  import srma_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] in_sample_temperature,
  input  logic        [FIELD_W-1:0] in_sample_humidity,
  input  logic        [FIELD_W-1:0] in_sample_lux,
  input  logic        [FIELD_W-1:0] in_sample_noise,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] out_avg_temperature,
  output logic        [FIELD_W-1:0] out_avg_humidity,
  output logic        [FIELD_W-1:0] out_avg_lux,
  output logic        [FIELD_W-1:0] out_avg_noise,
  output logic        [CNT_W-1:0]   out_valid_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic        [CNT_W-1:0]   cfg_record_count
);

`include "sensor_ring_moving_average_core_assert.svh"

  srma_cmd_t  cmd;
  srma_stat_t stat;
  logic       avg_all_zero;

  srma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  srma_dp #(
    .RING_SLOTS (RING_SLOTS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg_record_count      (cfg_record_count),
    .in_sample_temperature (in_sample_temperature),
    .in_sample_humidity    (in_sample_humidity),
    .in_sample_lux         (in_sample_lux),
    .in_sample_noise       (in_sample_noise),
    .out_avg_temperature   (out_avg_temperature),
    .out_avg_humidity      (out_avg_humidity),
    .out_avg_lux           (out_avg_lux),
    .out_avg_noise         (out_avg_noise),
    .out_valid_count       (out_valid_count)
  );

  assign avg_all_zero = (out_avg_temperature == '0) && (out_avg_humidity == '0) &&
                        (out_avg_lux == '0) && (out_avg_noise == '0);

  `SRMA_ASSERT_NXT(a_busy_after_item, clk, rst_n, in_valid && !in_stall, in_stall)
  `SRMA_ASSERT_NXT(a_clear_after_cfg, clk, rst_n, cfg_valid && cfg_ready, in_stall)
  `SRMA_ASSERT_IMP(a_empty_means_zero, clk, rst_n, out_valid && (out_valid_count == '0), avg_all_zero)

endmodule
